// ===== rtl/core/vcs_pkg.sv =====
// ----------------------------------------------------------------------------
// vcs_pkg
// Shared types and fixed field widths of the voxel color store.
// ----------------------------------------------------------------------------
package vcs_pkg;

   localparam int POS_W       = 16;
   localparam int COLOR_W     = 8;
   localparam int COORD_OUT_W = 4;
   localparam int DIM_W       = 5;
   localparam int CSR_IDX_W   = 2;

   typedef enum logic [1:0] {
      OP_SET    = 2'd0,
      OP_ERASE  = 2'd1,
      OP_READ   = 2'd2,
      OP_BOUNDS = 2'd3
   } op_type;

   localparam logic [CSR_IDX_W-1:0] CSR_DIM_X = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DIM_Y = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DIM_Z = 2'd2;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MUL1,
      ST_MUL2,
      ST_ACCESS,
      ST_DATA,
      ST_SCAN,
      ST_DRAIN,
      ST_DONE
   } state_type;

endpackage

// ===== rtl/core/vcs_req_if.sv =====
// ----------------------------------------------------------------------------
// vcs_req_if
// Request channel of the voxel color store: one operation per beat.
// ----------------------------------------------------------------------------
interface vcs_req_if;
   import vcs_pkg::*;

   logic                valid;
   logic                ready;
   op_type              op;
   logic [POS_W-1:0]    pos_x;
   logic [POS_W-1:0]    pos_y;
   logic [POS_W-1:0]    pos_z;
   logic [COLOR_W-1:0]  color;

   modport source (output valid, op, pos_x, pos_y, pos_z, color, input ready);
   modport sink   (input valid, op, pos_x, pos_y, pos_z, color, output ready);
endinterface

// ===== rtl/core/vcs_rsp_if.sv =====
// ----------------------------------------------------------------------------
// vcs_rsp_if
// Response channel of the voxel color store: one result per beat.
// ----------------------------------------------------------------------------
interface vcs_rsp_if;
   import vcs_pkg::*;

   logic                   valid;
   logic                   ready;
   logic                   ok;
   logic [COLOR_W-1:0]     color_out;
   logic [COORD_OUT_W-1:0] lo_x;
   logic [COORD_OUT_W-1:0] lo_y;
   logic [COORD_OUT_W-1:0] lo_z;
   logic [COORD_OUT_W-1:0] hi_x;
   logic [COORD_OUT_W-1:0] hi_y;
   logic [COORD_OUT_W-1:0] hi_z;

   modport source (output valid, ok, color_out, lo_x, lo_y, lo_z, hi_x, hi_y, hi_z,
                   input ready);
   modport sink   (input valid, ok, color_out, lo_x, lo_y, lo_z, hi_x, hi_y, hi_z,
                   output ready);
endinterface

// ===== rtl/core/vcs_ram.sv =====
// ----------------------------------------------------------------------------
// vcs_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module vcs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                                       clock,
   input  logic                                       we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                           wdata,
   input  logic                                       re,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                           rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/core/vcs_mac.sv =====
// ----------------------------------------------------------------------------
// vcs_mac
// Shared multiply-add unit with a registered result, used twice per address.
// ----------------------------------------------------------------------------
module vcs_mac #(
   parameter int AW = 12,
   parameter int DW = 5,
   parameter int CW = 4
) (
   input  logic          clock,
   input  logic          en,
   input  logic [AW-1:0] a,
   input  logic [DW-1:0] b,
   input  logic [CW-1:0] c,
   output logic [AW-1:0] res
);

   localparam int PW = AW + DW;

   logic [PW-1:0] prod;
   logic [AW-1:0] res_in;
   logic [AW-1:0] res_ff;

   assign prod   = PW'(a) * PW'(b) + PW'(c);
   assign res_in = prod[AW-1:0];

   always_ff @(posedge clock) begin
      if (en) begin
         res_ff <= res_in;
      end
   end

   assign res = res_ff;

endmodule

// ===== rtl/core/vcs_seq.sv =====
// ----------------------------------------------------------------------------
// vcs_seq
// Operation sequencer: address build on the shared multiply-add unit, point
// access, clearing sweep, bounds scan and the response register.
// ----------------------------------------------------------------------------
module vcs_seq #(
   parameter int MAX_DIM    = 16,
   parameter int COLOR_BITS = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   cfg_clear,
   input  logic [$clog2(MAX_DIM+1)-1:0] dim_x,
   input  logic [$clog2(MAX_DIM+1)-1:0] dim_y,
   input  logic [$clog2(MAX_DIM+1)-1:0] dim_z,
   vcs_req_if.sink                req_bus,
   vcs_rsp_if.source              rsp_bus
);
   import vcs_pkg::*;

   localparam int CW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int DW    = $clog2(MAX_DIM + 1);
   localparam int DEPTH = MAX_DIM * MAX_DIM * MAX_DIM;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   state_type state_ff, state_in;

   // Latched request.
   op_type                op_ff;
   logic                  hit_ff;
   logic [COLOR_BITS-1:0] color_ff;
   logic [CW-1:0]         x_ff, y_ff, z_ff;

   // Clearing sweep and scan counters.
   logic [AW-1:0] clr_addr_ff, clr_addr_in;
   logic [AW-1:0] scan_addr_ff, scan_addr_in;
   logic [CW-1:0] sx_ff, sy_ff, sz_ff, sx_in, sy_in, sz_in;
   logic          pv_ff, pv_in;
   logic [CW-1:0] px_ff, py_ff, pz_ff;
   logic          found_ff, found_in;
   logic [CW-1:0] lo_x_ff, lo_y_ff, lo_z_ff, hi_x_ff, hi_y_ff, hi_z_ff;
   logic [CW-1:0] lo_x_in, lo_y_in, lo_z_in, hi_x_in, hi_y_in, hi_z_in;

   // Response register.
   logic                   rsp_valid_ff;
   logic                   rsp_ok_ff, rsp_ok_in;
   logic [COLOR_W-1:0]     rsp_color_ff, rsp_color_in;
   logic [COORD_OUT_W-1:0] rsp_lo_x_ff, rsp_lo_y_ff, rsp_lo_z_ff;
   logic [COORD_OUT_W-1:0] rsp_hi_x_ff, rsp_hi_y_ff, rsp_hi_z_ff;

   // Memory and multiply-add hookup.
   logic                  mem_we, mem_re;
   logic [AW-1:0]         mem_waddr, mem_raddr;
   logic [COLOR_BITS-1:0] mem_wdata, mem_rdata;
   logic                  mac_en;
   logic [AW-1:0]         mac_a, mac_res;
   logic [DW-1:0]         mac_b;
   logic [CW-1:0]         mac_c;

   logic accept, out_free, load_out, dims_zero, scan_last;
   logic sx_last, sy_last, sz_last;
   logic in_x, in_y, in_z;
   logic [15:0]           color_wide_in, color_wide_out;
   logic [7:0]            lo_x_w, lo_y_w, lo_z_w, hi_x_w, hi_y_w, hi_z_w;
   logic                  set_ok, erase_ok;

   vcs_ram #(.WIDTH(COLOR_BITS), .DEPTH(DEPTH)) u_ram (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .re    (mem_re),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   vcs_mac #(.AW(AW), .DW(DW), .CW(CW)) u_mac (
      .clock (clock),
      .en    (mac_en),
      .a     (mac_a),
      .b     (mac_b),
      .c     (mac_c),
      .res   (mac_res)
   );

   assign accept    = req_bus.valid && (state_ff == ST_IDLE);
   assign out_free  = !rsp_valid_ff || rsp_bus.ready;
   assign dims_zero = (dim_x == '0) || (dim_y == '0) || (dim_z == '0);

   // A coordinate is in bounds when it is non-negative and below its dimension.
   assign in_x = !req_bus.pos_x[POS_W-1] && (req_bus.pos_x[POS_W-2:0] < (POS_W-1)'(dim_x));
   assign in_y = !req_bus.pos_y[POS_W-1] && (req_bus.pos_y[POS_W-2:0] < (POS_W-1)'(dim_y));
   assign in_z = !req_bus.pos_z[POS_W-1] && (req_bus.pos_z[POS_W-2:0] < (POS_W-1)'(dim_z));

   assign color_wide_in = 16'(req_bus.color);

   assign sx_last   = (DW'(sx_ff) == dim_x - DW'(1));
   assign sy_last   = (DW'(sy_ff) == dim_y - DW'(1));
   assign sz_last   = (DW'(sz_ff) == dim_z - DW'(1));
   assign scan_last = sx_last && sy_last && sz_last;

   assign set_ok   = hit_ff && (color_ff != '0);
   assign erase_ok = hit_ff && (mem_rdata != '0);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_addr_ff == AW'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_bus.valid) begin
               if (req_bus.op == OP_BOUNDS) begin
                  state_in = dims_zero ? ST_DONE : ST_SCAN;
               end else begin
                  state_in = ST_MUL1;
               end
            end
         end
         ST_MUL1:   state_in = ST_MUL2;
         ST_MUL2:   state_in = ST_ACCESS;
         ST_ACCESS: state_in = ST_DATA;
         ST_DATA: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_SCAN: begin
            if (scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN:  state_in = ST_DONE;
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
      if (cfg_clear) begin
         state_in = ST_CLEAR;
      end
   end

   // Outputs of the sequencer.
   always_comb begin
      req_bus.ready = 1'b0;
      mac_en        = 1'b0;
      mac_a         = mac_res;
      mac_b         = dim_x;
      mac_c         = x_ff;
      mem_re        = 1'b0;
      mem_raddr     = mac_res;
      mem_we        = 1'b0;
      mem_waddr     = mac_res;
      mem_wdata     = '0;
      load_out      = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_ff;
         end
         ST_IDLE: begin
            req_bus.ready = 1'b1;
         end
         ST_MUL1: begin
            mac_en = 1'b1;
            mac_a  = AW'(z_ff);
            mac_b  = dim_y;
            mac_c  = y_ff;
         end
         ST_MUL2: begin
            mac_en = 1'b1;
         end
         ST_ACCESS: begin
            mem_re = 1'b1;
         end
         ST_DATA: begin
            load_out = out_free;
            if (out_free && (op_ff == OP_SET) && set_ok) begin
               mem_we    = 1'b1;
               mem_wdata = color_ff;
            end
            if (out_free && (op_ff == OP_ERASE) && erase_ok) begin
               mem_we = 1'b1;
            end
         end
         ST_SCAN: begin
            mem_re    = 1'b1;
            mem_raddr = scan_addr_ff;
         end
         ST_DRAIN: begin
         end
         ST_DONE: begin
            load_out = out_free;
         end
         default: begin
         end
      endcase
   end

   // Scan bookkeeping and min/max tracking of the read pipeline.
   always_comb begin
      clr_addr_in  = (state_ff == ST_CLEAR) ? AW'(clr_addr_ff + AW'(1)) : '0;
      scan_addr_in = scan_addr_ff;
      sx_in        = sx_ff;
      sy_in        = sy_ff;
      sz_in        = sz_ff;
      pv_in        = 1'b0;
      found_in     = found_ff;
      lo_x_in      = lo_x_ff;
      lo_y_in      = lo_y_ff;
      lo_z_in      = lo_z_ff;
      hi_x_in      = hi_x_ff;
      hi_y_in      = hi_y_ff;
      hi_z_in      = hi_z_ff;
      if (accept) begin
         scan_addr_in = '0;
         sx_in        = '0;
         sy_in        = '0;
         sz_in        = '0;
         found_in     = 1'b0;
         lo_x_in      = '0;
         lo_y_in      = '0;
         lo_z_in      = '0;
         hi_x_in      = '0;
         hi_y_in      = '0;
         hi_z_in      = '0;
      end else begin
         if (state_ff == ST_SCAN) begin
            pv_in        = 1'b1;
            scan_addr_in = AW'(scan_addr_ff + AW'(1));
            if (sx_last) begin
               sx_in = '0;
               if (sy_last) begin
                  sy_in = '0;
                  sz_in = CW'(sz_ff + CW'(1));
               end else begin
                  sy_in = CW'(sy_ff + CW'(1));
               end
            end else begin
               sx_in = CW'(sx_ff + CW'(1));
            end
         end
         if (pv_ff && (mem_rdata != '0)) begin
            found_in = 1'b1;
            if (!found_ff) begin
               lo_x_in = px_ff;
               lo_y_in = py_ff;
               lo_z_in = pz_ff;
               hi_x_in = px_ff;
               hi_y_in = py_ff;
               hi_z_in = pz_ff;
            end else begin
               if (px_ff < lo_x_ff) lo_x_in = px_ff;
               if (py_ff < lo_y_ff) lo_y_in = py_ff;
               if (pz_ff < lo_z_ff) lo_z_in = pz_ff;
               if (px_ff > hi_x_ff) hi_x_in = px_ff;
               if (py_ff > hi_y_ff) hi_y_in = py_ff;
               if (pz_ff > hi_z_ff) hi_z_in = pz_ff;
            end
         end
      end
   end

   // Result of the finishing operation.
   assign color_wide_out = 16'(mem_rdata);
   assign lo_x_w = 8'(lo_x_ff);
   assign lo_y_w = 8'(lo_y_ff);
   assign lo_z_w = 8'(lo_z_ff);
   assign hi_x_w = 8'(hi_x_ff);
   assign hi_y_w = 8'(hi_y_ff);
   assign hi_z_w = 8'(hi_z_ff);

   always_comb begin
      rsp_ok_in    = 1'b0;
      rsp_color_in = '0;
      case (op_ff)
         OP_SET:    rsp_ok_in = set_ok;
         OP_ERASE:  rsp_ok_in = erase_ok;
         OP_READ:   rsp_color_in = hit_ff ? color_wide_out[COLOR_W-1:0] : '0;
         OP_BOUNDS: rsp_ok_in = found_ff;
         default:   rsp_ok_in = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         pv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         pv_ff        <= pv_in;
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff    <= req_bus.op;
         hit_ff   <= in_x && in_y && in_z;
         color_ff <= color_wide_in[COLOR_BITS-1:0];
         x_ff     <= req_bus.pos_x[CW-1:0];
         y_ff     <= req_bus.pos_y[CW-1:0];
         z_ff     <= req_bus.pos_z[CW-1:0];
      end
      scan_addr_ff <= scan_addr_in;
      sx_ff        <= sx_in;
      sy_ff        <= sy_in;
      sz_ff        <= sz_in;
      px_ff        <= sx_ff;
      py_ff        <= sy_ff;
      pz_ff        <= sz_ff;
      found_ff     <= found_in;
      lo_x_ff      <= lo_x_in;
      lo_y_ff      <= lo_y_in;
      lo_z_ff      <= lo_z_in;
      hi_x_ff      <= hi_x_in;
      hi_y_ff      <= hi_y_in;
      hi_z_ff      <= hi_z_in;
      if (load_out) begin
         rsp_ok_ff    <= rsp_ok_in;
         rsp_color_ff <= rsp_color_in;
         if (op_ff == OP_BOUNDS) begin
            rsp_lo_x_ff <= lo_x_w[COORD_OUT_W-1:0];
            rsp_lo_y_ff <= lo_y_w[COORD_OUT_W-1:0];
            rsp_lo_z_ff <= lo_z_w[COORD_OUT_W-1:0];
            rsp_hi_x_ff <= hi_x_w[COORD_OUT_W-1:0];
            rsp_hi_y_ff <= hi_y_w[COORD_OUT_W-1:0];
            rsp_hi_z_ff <= hi_z_w[COORD_OUT_W-1:0];
         end else begin
            rsp_lo_x_ff <= '0;
            rsp_lo_y_ff <= '0;
            rsp_lo_z_ff <= '0;
            rsp_hi_x_ff <= '0;
            rsp_hi_y_ff <= '0;
            rsp_hi_z_ff <= '0;
         end
      end
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.ok        = rsp_ok_ff;
   assign rsp_bus.color_out = rsp_color_ff;
   assign rsp_bus.lo_x      = rsp_lo_x_ff;
   assign rsp_bus.lo_y      = rsp_lo_y_ff;
   assign rsp_bus.lo_z      = rsp_lo_z_ff;
   assign rsp_bus.hi_x      = rsp_hi_x_ff;
   assign rsp_bus.hi_y      = rsp_hi_y_ff;
   assign rsp_bus.hi_z      = rsp_hi_z_ff;

   // The scan address always matches the z-major address of the counters.
   a_scan_addr: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |->
         (int'(scan_addr_ff) ==
          (int'(sz_ff) * int'(dim_y) + int'(sy_ff)) * int'(dim_x) + int'(sx_ff)))
      else $error("scan address out of step with scan counters");

   // The store is never written while a bounds scan is running.
   a_no_write_scan: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_SCAN) || (state_ff == ST_DRAIN)) |-> !mem_we)
      else $error("memory write during bounds scan");

   // The clearing sweep writes zero on every cycle.
   a_clear_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> (mem_we && (mem_wdata == '0)))
      else $error("clearing sweep missed a write");

   // An accepted beat always starts work; the block leaves the idle state.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (accept && !cfg_clear) |=> (state_ff != ST_IDLE) && !req_bus.ready)
      else $error("request accepted but sequencer stayed idle");

endmodule

// ===== rtl/core/voxel_color_store.sv =====
// ----------------------------------------------------------------------------
// voxel_color_store
// Dense voxel color store with set, erase, read and bounds query operations.
// ----------------------------------------------------------------------------
// Set, erase and read run through accept, two passes through the shared
// multiply-add unit for the address, one registered memory read and finish.
// A bounds query reads the dim_x*dim_y*dim_z cells, one memory read a cycle,
// then drains the read pipeline; it skips the scan when any dimension is zero.
// Reset (synchronous, active high) and every dimension write start a clearing
// sweep of all MAX_DIM^3 cells (4096 by default) during which no request is taken.
// ----------------------------------------------------------------------------
module voxel_color_store #(
   parameter int MAX_DIM    = 16,
   parameter int COLOR_BITS = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [vcs_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [vcs_pkg::DIM_W-1:0]       csr_wdata,
   vcs_req_if.sink                         req_bus,
   vcs_rsp_if.source                       rsp_bus
);
   import vcs_pkg::*;

   localparam int DW = $clog2(MAX_DIM + 1);

   logic [DIM_W-1:0] dim_x_ff, dim_y_ff, dim_z_ff;
   logic [DW-1:0]    eff_x, eff_y, eff_z;
   logic             cfg_clear;

   assign cfg_clear = csr_we &&
      ((csr_index == CSR_DIM_X) || (csr_index == CSR_DIM_Y) || (csr_index == CSR_DIM_Z));

   always_ff @(posedge clock) begin
      if (reset) begin
         dim_x_ff <= DIM_W'(16);
         dim_y_ff <= DIM_W'(16);
         dim_z_ff <= DIM_W'(16);
      end else if (csr_we) begin
         case (csr_index)
            CSR_DIM_X: dim_x_ff <= csr_wdata;
            CSR_DIM_Y: dim_y_ff <= csr_wdata;
            CSR_DIM_Z: dim_z_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Dimensions above the grid limit act as the limit.
   assign eff_x = (int'(dim_x_ff) > MAX_DIM) ? DW'(MAX_DIM) : DW'(dim_x_ff);
   assign eff_y = (int'(dim_y_ff) > MAX_DIM) ? DW'(MAX_DIM) : DW'(dim_y_ff);
   assign eff_z = (int'(dim_z_ff) > MAX_DIM) ? DW'(MAX_DIM) : DW'(dim_z_ff);

   vcs_seq #(.MAX_DIM(MAX_DIM), .COLOR_BITS(COLOR_BITS)) u_seq (
      .clock     (clock),
      .reset     (reset),
      .cfg_clear (cfg_clear),
      .dim_x     (eff_x),
      .dim_y     (eff_y),
      .dim_z     (eff_z),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus)
   );

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for voxel_color_store. A shadow copy of the voxel grid
// predicts every response beat; requests and responses see random stalls.
// ----------------------------------------------------------------------------
module testbench;
   import vcs_pkg::*;

   localparam int GRID_MAX   = 16;
   localparam int GRID_CELLS = GRID_MAX * GRID_MAX * GRID_MAX;
   localparam int IDLE_LIMIT = 60000;
   localparam int SHOW_LIMIT = 40;

   // Index 3 has no register behind it; writes there must be ignored.
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   typedef struct packed {
      op_type      op;
      logic [15:0] pos_x;
      logic [15:0] pos_y;
      logic [15:0] pos_z;
      logic [7:0]  color;
   } store_cmd_type;

   typedef struct packed {
      logic       ok;
      logic [7:0] color_out;
      logic [3:0] lo_x;
      logic [3:0] lo_y;
      logic [3:0] lo_z;
      logic [3:0] hi_x;
      logic [3:0] hi_y;
      logic [3:0] hi_z;
   } store_reply_type;

   typedef struct packed {
      logic [15:0] x;
      logic [15:0] y;
      logic [15:0] z;
   } grid_spot_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [DIM_W-1:0] csr_wdata;

   vcs_req_if req_bus ();
   vcs_rsp_if rsp_bus ();

   voxel_color_store dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus)
   );

   // Shadow of the store and its geometry.
   logic [7:0] voxel_shadow [0:GRID_CELLS-1];
   logic [DIM_W-1:0] grid_x;
   logic [DIM_W-1:0] grid_y;
   logic [DIM_W-1:0] grid_z;

   store_cmd_type   cmd_backlog [$];
   store_reply_type expected_replies [$];
   grid_spot_type   recent_spots [$];

   int  error_count;
   int  replies_seen;
   int  req_beats;
   int  beats_driven;
   int  req_gap;
   int  rsp_stall;
   int  idle_cycles;
   bit  req_busy;
   bit  no_idle;

   always #10 clock = ~clock;

   function automatic int eff_size(logic [DIM_W-1:0] d);
      return (d > GRID_MAX) ? GRID_MAX : int'(d);
   endfunction

   function automatic bit in_grid(logic [15:0] v, int dim);
      return (v[15] == 1'b0) && (int'(v) < dim);
   endfunction

   function automatic void clear_shadow();
      foreach (voxel_shadow[i]) voxel_shadow[i] = 8'd0;
   endfunction

   // Applies one command to the shadow grid and returns the response beat.
   function automatic store_reply_type apply_voxel_op(store_cmd_type c);
      store_reply_type r;
      int dx, dy, dz, addr, x, y, z;
      int lx, ly, lz, hx, hy, hz;
      bit hit, found;
      r  = '0;
      dx = eff_size(grid_x);
      dy = eff_size(grid_y);
      dz = eff_size(grid_z);
      hit = in_grid(c.pos_x, dx) && in_grid(c.pos_y, dy) && in_grid(c.pos_z, dz);
      addr = 0;
      if (hit) begin
         addr = (int'(c.pos_z) * dy + int'(c.pos_y)) * dx + int'(c.pos_x);
      end
      case (c.op)
         OP_SET: begin
            if (c.color != 8'd0 && hit) begin
               voxel_shadow[addr] = c.color;
               r.ok = 1'b1;
            end
         end
         OP_ERASE: begin
            if (hit && voxel_shadow[addr] != 8'd0) begin
               voxel_shadow[addr] = 8'd0;
               r.ok = 1'b1;
            end
         end
         OP_READ: begin
            if (hit) r.color_out = voxel_shadow[addr];
         end
         default: begin
            found = 1'b0;
            lx = 0; ly = 0; lz = 0; hx = 0; hy = 0; hz = 0;
            for (z = 0; z < dz; z++) begin
               for (y = 0; y < dy; y++) begin
                  for (x = 0; x < dx; x++) begin
                     if (voxel_shadow[(z * dy + y) * dx + x] != 8'd0) begin
                        if (!found) begin
                           lx = x; ly = y; lz = z; hx = x; hy = y; hz = z;
                           found = 1'b1;
                        end else begin
                           if (x < lx) lx = x;
                           if (y < ly) ly = y;
                           if (z < lz) lz = z;
                           if (x > hx) hx = x;
                           if (y > hy) hy = y;
                           if (z > hz) hz = z;
                        end
                     end
                  end
               end
            end
            if (found) begin
               r.ok   = 1'b1;
               r.lo_x = lx[3:0];
               r.lo_y = ly[3:0];
               r.lo_z = lz[3:0];
               r.hi_x = hx[3:0];
               r.hi_y = hy[3:0];
               r.hi_z = hz[3:0];
            end
         end
      endcase
      return r;
   endfunction

   // Mostly back-to-back, sometimes a short pause, rarely a long one.
   function automatic int pick_gap();
      int r;
      if (no_idle) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(6, 30);
   endfunction

   function automatic logic [15:0] pick_coord(int dim);
      int r;
      r = $urandom_range(0, 99);
      if (r < 85 && dim > 0) return 16'($urandom_range(0, dim - 1));
      if (r < 88) return 16'(dim);
      if (r < 92) return 16'(0 - int'($urandom_range(1, 40)));
      if (r < 96) return 16'($urandom());
      case ($urandom_range(0, 2))
         0: return 16'h8000;
         1: return 16'h7FFF;
         default: return 16'hFFFF;
      endcase
   endfunction

   function automatic store_cmd_type make_cmd(int bounds_pct);
      store_cmd_type c;
      grid_spot_type s;
      int r;
      c.pos_x = pick_coord(eff_size(grid_x));
      c.pos_y = pick_coord(eff_size(grid_y));
      c.pos_z = pick_coord(eff_size(grid_z));
      r = $urandom_range(0, 99);
      c.color = (r < 8) ? 8'd0 : (r < 13) ? 8'hFF : 8'($urandom_range(1, 254));
      r = $urandom_range(0, 99);
      if (r < bounds_pct) begin
         c.op = OP_BOUNDS;
         return c;
      end
      r = $urandom_range(0, 99);
      c.op = (r < 40) ? OP_SET : (r < 65) ? OP_ERASE : OP_READ;
      // Revisit earlier set positions so erases and reads find something.
      if (recent_spots.size() > 0 && (c.op != OP_SET || $urandom_range(0, 4) == 0)
          && $urandom_range(0, 1) == 1) begin
         s = recent_spots[$urandom_range(0, recent_spots.size() - 1)];
         c.pos_x = s.x;
         c.pos_y = s.y;
         c.pos_z = s.z;
      end else if (c.op == OP_SET) begin
         s.x = c.pos_x;
         s.y = c.pos_y;
         s.z = c.pos_z;
         recent_spots.insert(recent_spots.size(), s);
         if (recent_spots.size() > 24) void'(recent_spots.pop_front());
      end
      return c;
   endfunction

   task automatic push_cmd(op_type op, logic [15:0] x, logic [15:0] y, logic [15:0] z,
                           logic [7:0] color);
      store_cmd_type c;
      c.op    = op;
      c.pos_x = x;
      c.pos_y = y;
      c.pos_z = z;
      c.color = color;
      cmd_backlog.insert(cmd_backlog.size(), c);
   endtask

   task automatic log_mismatch(string msg);
      error_count++;
      if (error_count <= SHOW_LIMIT) $display("%0t mismatch: %s", $realtime, msg);
   endtask

   task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
      if (got !== want) begin
         log_mismatch($sformatf("reply %0d %s: got %0h, expected %0h",
                                replies_seen, name, got, want));
      end
   endtask

   task automatic wait_drained();
      while (cmd_backlog.size() != 0 || req_busy || expected_replies.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // Consecutive writes keep csr_we high; csr_release drops it afterwards.
   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [DIM_W-1:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_DIM_X: grid_x = val;
         CSR_DIM_Y: grid_y = val;
         CSR_DIM_Z: grid_z = val;
         default: return;
      endcase
      clear_shadow();
   endtask

   task automatic csr_release();
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic run_phase(logic [DIM_W-1:0] x, logic [DIM_W-1:0] y,
                            logic [DIM_W-1:0] z, int count, int bounds_pct, bit calm);
      int i;
      wait_drained();
      csr_write(CSR_DIM_X, x);
      csr_write(CSR_DIM_Y, y);
      csr_write(CSR_DIM_Z, z);
      csr_release();
      no_idle = calm;
      recent_spots.delete();
      for (i = 0; i < count; i++) cmd_backlog.insert(cmd_backlog.size(), make_cmd(bounds_pct));
   endtask

   always @(negedge clock) begin : req_driver
      store_cmd_type nxt;
      if (reset) begin
         req_bus.valid <= 1'b0;
         req_busy = 1'b0;
         req_gap = 0;
         beats_driven = 0;
      end else begin
         if (req_busy && req_beats != beats_driven) begin
            beats_driven = req_beats;
            req_busy = 1'b0;
            req_gap = pick_gap();
         end
         if (!req_busy) begin
            if (req_gap > 0) begin
               req_gap--;
            end else if (cmd_backlog.size() > 0) begin
               nxt = cmd_backlog.pop_front();
               req_bus.op    <= nxt.op;
               req_bus.pos_x <= nxt.pos_x;
               req_bus.pos_y <= nxt.pos_y;
               req_bus.pos_z <= nxt.pos_z;
               req_bus.color <= nxt.color;
               req_busy = 1'b1;
            end
         end
         req_bus.valid <= req_busy;
      end
   end

   always @(negedge clock) begin : rsp_driver
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         rsp_stall = 0;
      end else if (rsp_stall > 0) begin
         rsp_stall--;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
         if ($urandom_range(0, 3) == 0) rsp_stall = pick_gap();
      end
   end

   always @(posedge clock) begin : monitor
      store_cmd_type   c;
      store_reply_type got;
      store_reply_type want;
      bit beat;
      if (!reset) begin
         beat = 1'b0;
         if (req_bus.valid && req_bus.ready) begin
            c.op    = req_bus.op;
            c.pos_x = req_bus.pos_x;
            c.pos_y = req_bus.pos_y;
            c.pos_z = req_bus.pos_z;
            c.color = req_bus.color;
            expected_replies.insert(expected_replies.size(), apply_voxel_op(c));
            req_beats++;
            beat = 1'b1;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.ok        = rsp_bus.ok;
            got.color_out = rsp_bus.color_out;
            got.lo_x      = rsp_bus.lo_x;
            got.lo_y      = rsp_bus.lo_y;
            got.lo_z      = rsp_bus.lo_z;
            got.hi_x      = rsp_bus.hi_x;
            got.hi_y      = rsp_bus.hi_y;
            got.hi_z      = rsp_bus.hi_z;
            if (expected_replies.size() == 0) begin
               log_mismatch($sformatf("reply %0d arrived with no request outstanding",
                                      replies_seen));
            end else begin
               want = expected_replies.pop_front();
               check_field("ok", 8'(got.ok), 8'(want.ok));
               check_field("color_out", got.color_out, want.color_out);
               check_field("lo_x", 8'(got.lo_x), 8'(want.lo_x));
               check_field("lo_y", 8'(got.lo_y), 8'(want.lo_y));
               check_field("lo_z", 8'(got.lo_z), 8'(want.lo_z));
               check_field("hi_x", 8'(got.hi_x), 8'(want.hi_x));
               check_field("hi_y", 8'(got.hi_y), 8'(want.hi_y));
               check_field("hi_z", 8'(got.hi_z), 8'(want.hi_z));
            end
            replies_seen++;
            beat = 1'b1;
         end
         idle_cycles = beat ? 0 : idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no beat for %0d cycles, %0d replies outstanding",
                     idle_cycles, expected_replies.size());
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   initial begin : stimulus
      clock         = 1'b0;
      reset         = 1'b1;
      csr_we        = 1'b0;
      csr_index     = CSR_DIM_X;
      csr_wdata     = '0;
      req_bus.valid = 1'b0;
      req_bus.op    = OP_SET;
      req_bus.pos_x = '0;
      req_bus.pos_y = '0;
      req_bus.pos_z = '0;
      req_bus.color = '0;
      rsp_bus.ready = 1'b0;
      error_count   = 0;
      replies_seen  = 0;
      req_beats     = 0;
      beats_driven  = 0;
      req_gap       = 0;
      rsp_stall     = 0;
      idle_cycles   = 0;
      req_busy      = 1'b0;
      no_idle       = 1'b0;
      grid_x        = 5'd16;
      grid_y        = 5'd16;
      grid_z        = 5'd16;
      clear_shadow();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: empty store, corners, rejected colors, out-of-range positions.
      push_cmd(OP_BOUNDS, 16'd0, 16'd0, 16'd0, 8'd0);
      push_cmd(OP_READ, 16'd0, 16'd0, 16'd0, 8'd0);
      push_cmd(OP_SET, 16'd0, 16'd0, 16'd0, 8'd1);
      push_cmd(OP_SET, 16'd15, 16'd15, 16'd15, 8'hFF);
      push_cmd(OP_SET, 16'd3, 16'd4, 16'd5, 8'd0);
      push_cmd(OP_SET, 16'd16, 16'd0, 16'd0, 8'd9);
      push_cmd(OP_SET, 16'd0, 16'hFFFF, 16'd0, 8'd9);
      push_cmd(OP_SET, 16'd0, 16'd0, 16'h8000, 8'd9);
      push_cmd(OP_SET, 16'h7FFF, 16'd0, 16'd0, 8'd9);
      push_cmd(OP_READ, 16'd15, 16'd15, 16'd15, 8'd0);
      push_cmd(OP_READ, 16'd3, 16'd4, 16'd5, 8'd0);
      push_cmd(OP_READ, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'h55);
      push_cmd(OP_BOUNDS, 16'hFFFF, 16'h8000, 16'h7FFF, 8'hFF);
      push_cmd(OP_ERASE, 16'd0, 16'd0, 16'd0, 8'd0);
      push_cmd(OP_ERASE, 16'd0, 16'd0, 16'd0, 8'd0);
      push_cmd(OP_ERASE, 16'd0, 16'd16, 16'd0, 8'd0);
      push_cmd(OP_BOUNDS, 16'd0, 16'd0, 16'd0, 8'd0);
      push_cmd(OP_SET, 16'd15, 16'd15, 16'd15, 8'hAA);
      push_cmd(OP_READ, 16'd15, 16'd15, 16'd15, 8'd0);

      // A write to the unused index must leave the grid and the store alone.
      wait_drained();
      csr_write(CSR_SPARE, 5'd5);
      csr_release();
      push_cmd(OP_READ, 16'd15, 16'd15, 16'd15, 8'd0);
      push_cmd(OP_READ, 16'd5, 16'd0, 16'd0, 8'd0);

      // Full-size grids make the bounds scan slow, so queries stay rare there.
      run_phase(5'd31, 5'd31, 5'd31, 150, 1, 1'b0);
      run_phase(5'd0, 5'd5, 5'd7, 60, 20, 1'b0);
      run_phase(5'd1, 5'd1, 5'd1, 120, 20, 1'b1);
      run_phase(5'd4, 5'd3, 5'd5, 300, 15, 1'b0);
      run_phase(5'd16, 5'd1, 5'd2, 200, 10, 1'b0);
      run_phase(5'd7, 5'd16, 5'd3, 200, 8, 1'b1);
      run_phase(5'd2, 5'd2, 5'd2, 200, 20, 1'b0);
      run_phase(5'd16, 5'd16, 5'd16, 150, 2, 1'b0);
      run_phase(5'd5, 5'd0, 5'd16, 40, 20, 1'b0);
      run_phase(5'd3, 5'd9, 5'd1, 130, 15, 1'b0);

      wait_drained();
      repeat (50) @(posedge clock);
      if (expected_replies.size() != 0) begin
         log_mismatch($sformatf("%0d replies never arrived", expected_replies.size()));
      end
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/vcs_pkg.sv
rtl/core/vcs_req_if.sv
rtl/core/vcs_rsp_if.sv
rtl/core/vcs_ram.sv
rtl/core/vcs_mac.sv
rtl/core/vcs_seq.sv
rtl/core/voxel_color_store.sv
dv/testbench.sv
